@@ design/hkrd_pkg.sv @@
// shared types, constants and the keycode to ascii lookup for the report differ
`default_nettype none
package hkrd_pkg;

  localparam int KEY_SLOTS  = 6;
  localparam int EVENT_BITS = 2 * KEY_SLOTS;
  localparam logic [7:0] SHIFT_BITS = 8'h22;

  typedef enum logic {
    CMD_REPORT     = 1'b0,
    CMD_DISCONNECT = 1'b1
  } command_t;

  typedef struct packed {
    logic       command;
    logic [7:0] modifier;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } report_t;

  typedef struct packed {
    logic [7:0] event_modifier;
    logic [7:0] event_keycode;
    logic [6:0] character;
    logic       pressed;
    logic       last;
  } result_t;

  typedef logic [KEY_SLOTS-1:0][7:0] slots_t;

  // one report worth of work handed from the front to the back
  typedef struct packed {
    logic [7:0]           modifier;
    slots_t               now_keys;
    slots_t               old_keys;
    logic [KEY_SLOTS-1:0] press_mask;
    logic [KEY_SLOTS-1:0] release_mask;
  } job_t;

  function automatic logic [6:0] char_of(input logic [7:0] code, input logic [7:0] modifier);
    logic       shifted;
    logic [7:0] plain;
    logic [7:0] upper;
    shifted = (modifier & SHIFT_BITS) != 8'h00;
    plain   = 8'h00;
    upper   = 8'h00;
    case (code) inside
      [8'd4:8'd29]: begin
        plain = code + 8'h5d;
        upper = code + 8'h3d;
      end
      [8'd30:8'd38]: begin
        plain = code + 8'h13;
      end
      default: begin
      end
    endcase
    case (code)
      8'd30: upper = 8'h21;
      8'd31: upper = 8'h40;
      8'd32: upper = 8'h23;
      8'd33: upper = 8'h24;
      8'd34: upper = 8'h25;
      8'd35: upper = 8'h5e;
      8'd36: upper = 8'h26;
      8'd37: upper = 8'h2a;
      8'd38: upper = 8'h28;
      8'd39: begin plain = 8'h30; upper = 8'h29; end
      8'd44: begin plain = 8'h20; upper = 8'h20; end
      8'd45: begin plain = 8'h2d; upper = 8'h5f; end
      8'd46: begin plain = 8'h3d; upper = 8'h2b; end
      8'd47: begin plain = 8'h5b; upper = 8'h7b; end
      8'd48: begin plain = 8'h5d; upper = 8'h7d; end
      8'd49: begin plain = 8'h5c; upper = 8'h7c; end
      8'd51: begin plain = 8'h3b; upper = 8'h3a; end
      8'd52: begin plain = 8'h27; upper = 8'h22; end
      8'd53: begin plain = 8'h60; upper = 8'h7e; end
      8'd54: begin plain = 8'h2c; upper = 8'h3c; end
      8'd55: begin plain = 8'h2e; upper = 8'h3e; end
      8'd56: begin plain = 8'h2f; upper = 8'h3f; end
      default: begin
      end
    endcase
    return shifted ? upper[6:0] : plain[6:0];
  endfunction

endpackage
`default_nettype wire

@@ design/hkrd_front.sv @@
// front end: compares each report with the stored slots and builds a job
`default_nettype none
module hkrd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire hkrd_pkg::report_t report,
  output logic                  job_push,
  output hkrd_pkg::job_t        job,
  input  wire logic             job_full
);

  hkrd_pkg::slots_t previous_keys;
  hkrd_pkg::slots_t now_keys;
  logic [hkrd_pkg::KEY_SLOTS-1:0] press_mask;
  logic [hkrd_pkg::KEY_SLOTS-1:0] release_mask;
  logic accept;

  assign now_keys = {report.key_5, report.key_4, report.key_3,
                     report.key_2, report.key_1, report.key_0};

  // every slot against every slot, all in parallel
  always_comb begin
    logic in_prev;
    logic in_now;
    for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) begin
      in_prev = 1'b0;
      in_now  = 1'b0;
      for (int j = 0; j < hkrd_pkg::KEY_SLOTS; j++) begin
        if (previous_keys[j] == now_keys[i]) in_prev = 1'b1;
        if (now_keys[j] == previous_keys[i]) in_now = 1'b1;
      end
      press_mask[i]   = (now_keys[i] != 8'h00) && !in_prev;
      release_mask[i] = (previous_keys[i] != 8'h00) && !in_now;
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  assign job.modifier     = report.modifier;
  assign job.now_keys     = now_keys;
  assign job.old_keys     = previous_keys;
  assign job.press_mask   = press_mask;
  assign job.release_mask = release_mask;

  // disconnects and unchanged reports produce no job
  assign job_push = accept && (report.command == hkrd_pkg::CMD_REPORT) &&
                    ((press_mask != '0) || (release_mask != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
    end else if (accept) begin
      if (report.command == hkrd_pkg::CMD_DISCONNECT) begin
        previous_keys <= '0;
      end else begin
        previous_keys <= now_keys;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/hkrd_queue.sv @@
// short job queue between the front end and the event sequencer
`default_nettype none
module hkrd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hkrd_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output hkrd_pkg::job_t      pop_data,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hkrd_pkg::job_t  entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/hkrd_back.sv @@
// back end: walks a job's press and release masks, one event per cycle unless a result is held
`default_nettype none
module hkrd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hkrd_pkg::job_t job,
  input  wire logic           job_empty,
  output logic                job_pop,
  output logic                empty,
  input  wire logic           pop,
  output hkrd_pkg::result_t   result
);

  localparam int K = hkrd_pkg::KEY_SLOTS;
  localparam int N = hkrd_pkg::EVENT_BITS;

  hkrd_pkg::job_t    cur;
  logic              busy;
  logic [N-1:0]      remain;
  logic [N-1:0]      lowest;
  logic [N-1:0]      remain_next;
  logic              advance;
  logic              emit;
  logic              finishing;
  logic              out_valid;
  logic [7:0]        keycode;
  hkrd_pkg::result_t event_word;

  assign lowest      = remain & (~remain + 1'b1);
  assign remain_next = remain & ~lowest;
  assign advance     = !out_valid || pop;
  assign emit        = busy && advance;
  assign finishing   = emit && (remain_next == '0);
  assign job_pop     = (!busy || finishing) && !job_empty;
  assign empty       = !out_valid;

  // presses sit in the low half of the mask, so they come out first
  always_comb begin
    keycode = 8'h00;
    for (int i = 0; i < K; i++) begin
      keycode = keycode | ({8{lowest[i]}} & cur.now_keys[i])
                        | ({8{lowest[K+i]}} & cur.old_keys[i]);
    end
  end

  assign event_word.event_modifier = cur.modifier;
  assign event_word.event_keycode  = keycode;
  assign event_word.character      = hkrd_pkg::char_of(keycode, cur.modifier);
  assign event_word.pressed        = lowest[K-1:0] != '0;
  assign event_word.last           = remain_next == '0;

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (emit) result <= event_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy   <= 1'b1;
        remain <= {job.release_mask, job.press_mask};
      end else if (finishing) begin
        busy   <= 1'b0;
        remain <= '0;
      end else if (emit) begin
        remain <= remain_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/hid_keyboard_report_differ_core.sv @@
// top level of the keyboard report differ: front end, job queue, event sequencer
//
//   channel   handshake      payload              direction
//   report    push / full    hkrd_pkg::report_t   in
//   result    empty / pop    hkrd_pkg::result_t   out
//
// a report is taken in any cycle the job queue has room and is compared with the
// stored slots in that same cycle; the sequencer issues one event per cycle while no
// result is held, so a report's n events (at most twelve) come out back to back, and
// its first event passes the queue entry, the job register and the result register
// reset clears the stored slots, the queue and the result valid flag
// a held result stalls only the sequencer; the queue absorbs reports until full
`default_nettype none
module hid_keyboard_report_differ_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire hkrd_pkg::report_t report,
  output logic                   empty,
  input  wire logic              pop,
  output hkrd_pkg::result_t      result
);

  hkrd_pkg::job_t front_job;
  hkrd_pkg::job_t back_job;
  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;

  hkrd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .report   (report),
    .job_push (job_push),
    .job      (front_job),
    .job_full (job_full)
  );

  hkrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (front_job),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (back_job),
    .empty     (job_empty)
  );

  hkrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_hid_keyboard_report_differ_core.sv @@
// testbench for the keyboard report differ: streams reports, predicts key events, checks them
module tb_hid_keyboard_report_differ_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REPORTS = 450;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 32;

  typedef bit [hkrd_pkg::KEY_SLOTS-1:0][7:0] key_row_t;

  class key_event_board;
    hkrd_pkg::result_t due_events[$];
    key_row_t held_keys;
    int       mismatches;
    string    lower_row   = "abcdefghijklmnopqrstuvwxyz1234567890";
    string    upper_row   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()";
    // code 50 has no character, its spot is a filler
    string    lower_punct = " -=[]\\ ;'`,./";
    string    upper_punct = " _+{}| :\"~<>?";

    function new();
      held_keys  = '0;
      mismatches = 0;
    endfunction

    function bit [6:0] ascii_of(bit [7:0] code, bit [7:0] mods);
      bit  shifted;
      byte c;
      shifted = (mods & hkrd_pkg::SHIFT_BITS) != 8'h00;
      c = 8'h00;
      if (code >= 8'd4 && code <= 8'd39)
        c = shifted ? upper_row[int'(code) - 4] : lower_row[int'(code) - 4];
      else if (code >= 8'd44 && code <= 8'd56 && code != 8'd50)
        c = shifted ? upper_punct[int'(code) - 44] : lower_punct[int'(code) - 44];
      return c[6:0];
    endfunction

    function bit has_key(bit [7:0] code, key_row_t row);
      for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        if (row[i] == code) return 1'b1;
      return 1'b0;
    endfunction

    function void note_report(hkrd_pkg::report_t r);
      key_row_t now;
      bit [7:0] codes[$];
      bit       downs[$];
      hkrd_pkg::result_t ev;
      if (r.command == hkrd_pkg::CMD_DISCONNECT) begin
        held_keys = '0;
        return;
      end
      now[0] = r.key_0;
      now[1] = r.key_1;
      now[2] = r.key_2;
      now[3] = r.key_3;
      now[4] = r.key_4;
      now[5] = r.key_5;
      for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        if (now[i] != 8'h00 && !has_key(now[i], held_keys)) begin
          codes.push_back(now[i]);
          downs.push_back(1'b1);
        end
      for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        if (held_keys[i] != 8'h00 && !has_key(held_keys[i], now)) begin
          codes.push_back(held_keys[i]);
          downs.push_back(1'b0);
        end
      for (int k = 0; k < codes.size(); k++) begin
        ev.event_modifier = r.modifier;
        ev.event_keycode  = codes[k];
        ev.character      = ascii_of(codes[k], r.modifier);
        ev.pressed        = downs[k];
        ev.last           = (k == codes.size() - 1);
        due_events.push_back(ev);
      end
      held_keys = now;
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task check_event(hkrd_pkg::result_t got);
      hkrd_pkg::result_t want;
      if (due_events.size() == 0) begin
        report_mismatch("unexpected event, keycode", got.event_keycode, 0);
        return;
      end
      want = due_events.pop_front();
      if (got.event_modifier !== want.event_modifier)
        report_mismatch("event_modifier", got.event_modifier, want.event_modifier);
      if (got.event_keycode !== want.event_keycode)
        report_mismatch("event_keycode", got.event_keycode, want.event_keycode);
      if (got.character !== want.character)
        report_mismatch("character", got.character, want.character);
      if (got.pressed !== want.pressed)
        report_mismatch("pressed", got.pressed, want.pressed);
      if (got.last !== want.last)
        report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  hkrd_pkg::report_t report = '0;
  logic              empty;
  logic              pop = 1'b0;
  hkrd_pkg::result_t result;

  key_event_board board = new();
  key_row_t       typing_keys = '0;
  bit             hold_request = 1'b0;
  bit             took;
  int             idle_cycles = 0;

  hid_keyboard_report_differ_core dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .report(report),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor both handshakes and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      took = 1'b0;
      if (push && !full) begin
        board.note_report(report);
        took = 1'b1;
      end
      if (pop && !empty) begin
        board.check_event(result);
        took = 1'b1;
      end
      if (took) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: changing stall modes, plus one long hold-off on request
  initial begin
    int mode;
    int phase_left;
    bit [7:0] stall_pattern;
    mode = 0;
    phase_left = 0;
    stall_pattern = 8'b1011_0010;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= stall_pattern[phase_left % 8];
        endcase
      end
    end
  end

  task automatic send_report(input hkrd_pkg::report_t r);
    push   <= 1'b1;
    report <= r;
    do @(posedge clk); while (full);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic hkrd_pkg::report_t with_keys(input hkrd_pkg::report_t r,
                                                  input key_row_t k);
    hkrd_pkg::report_t o;
    o = r;
    o.key_0 = k[0];
    o.key_1 = k[1];
    o.key_2 = k[2];
    o.key_3 = k[3];
    o.key_4 = k[4];
    o.key_5 = k[5];
    return o;
  endfunction

  function automatic hkrd_pkg::report_t key_report(input logic [7:0] mods,
                                                   input logic [7:0] k0,
                                                   input logic [7:0] k1, input logic [7:0] k2,
                                                   input logic [7:0] k3, input logic [7:0] k4,
                                                   input logic [7:0] k5);
    hkrd_pkg::report_t r;
    r = '0;
    r.command  = hkrd_pkg::CMD_REPORT;
    r.modifier = mods;
    return with_keys(r, {k5, k4, k3, k2, k1, k0});
  endfunction

  task automatic run_directed();
    hkrd_pkg::report_t quit_all;
    hkrd_pkg::report_t quit_none;
    quit_all          = '1;
    quit_all.command  = hkrd_pkg::CMD_DISCONNECT;
    quit_none         = '0;
    quit_none.command = hkrd_pkg::CMD_DISCONNECT;
    send_report(key_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_report(key_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
    send_report(key_report(8'h22, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
    // every slot swapped: six presses then six releases
    send_report(key_report(8'hff, 8'hff, 8'h80, 8'h7f, 8'h38, 8'h39, 8'h01));
    send_report(key_report(8'h02, 8'h1e, 8'h1e, 8'h1e, 8'd0, 8'd0, 8'd0));
    send_report(quit_all);
    send_report(key_report(8'h20, 8'h1e, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_report(key_report(8'h20, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49));
    send_report(key_report(8'h00, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49));
    send_report(key_report(8'h00, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55));
    send_report(key_report(8'h02, 8'd56, 8'd57, 8'd39, 8'd38, 8'd30, 8'd3));
    send_report(key_report(8'h80, 8'd0, 8'd29, 8'd0, 8'd4, 8'd0, 8'd0));
    send_report(key_report(8'h55, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0));
    send_report(key_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_report(quit_none);
    send_report(key_report(8'h22, 8'hfe, 8'h7e, 8'h40, 8'h64, 8'h65, 8'h28));
    send_report(key_report(8'h00, 8'hfe, 8'h7e, 8'h40, 8'h64, 8'h65, 8'h28));
    send_report(quit_all);
    send_report(key_report(8'haa, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
  endtask

  function automatic bit [7:0] pick_key();
    int w;
    w = $urandom_range(0, 99);
    if (w < 80) return 8'($urandom_range(4, 56));
    if (w < 90) return 8'($urandom_range(57, 255));
    return typing_keys[$urandom_range(0, hkrd_pkg::KEY_SLOTS - 1)];
  endfunction

  // mostly typing-like edits of the held keys, some noise and disconnects
  task automatic send_random_report();
    hkrd_pkg::report_t r;
    key_row_t junk;
    int       pick;
    int       slot;
    r = '0;
    r.command = hkrd_pkg::CMD_REPORT;
    case ($urandom_range(0, 4))
      0: r.modifier = 8'h00;
      1: r.modifier = 8'h02;
      2: r.modifier = 8'h20;
      3: r.modifier = 8'h22;
      default: r.modifier = 8'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++) junk[i] = 8'($urandom);
      r = with_keys(r, junk);
      r.command = hkrd_pkg::CMD_DISCONNECT;
      typing_keys = '0;
    end else begin
      if (pick < 15) begin
        for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
          typing_keys[i] = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
      end else if (pick < 20) begin
        typing_keys = '0;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          slot = $urandom_range(0, hkrd_pkg::KEY_SLOTS - 1);
          if (typing_keys[slot] != 8'h00 && $urandom_range(0, 1)) typing_keys[slot] = 8'h00;
          else typing_keys[slot] = pick_key();
        end
      end
      r = with_keys(r, typing_keys);
    end
    send_report(r);
  endtask

  task automatic run_random();
    int  sent;
    int  burst;
    int  gap;
    bit  held;
    sent = 0;
    held = 1'b0;
    while (sent < RANDOM_REPORTS) begin
      if (!held && sent >= HOLD_AT) begin
        // long receiver hold-off while reports keep coming back to back
        held = 1'b1;
        hold_request = 1'b1;
        repeat (40) begin
          send_random_report();
          sent++;
        end
      end
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_report();
        sent++;
      end
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(4, 30);
        default: gap = 0;
      endcase
      pause_sender(gap);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    push <= 1'b0;
    while (board.due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.due_events.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
